FILE: sv/qvt_pkg.sv
// ----------------------------------------------------------------------------
// qvt_pkg
// Shared types and constants of the quorum vote tally table.
// ----------------------------------------------------------------------------
`default_nettype none

package qvt_pkg;

   localparam int CMD_W      = 2;
   localparam int INDEX_W    = 4;
   localparam int STATUS_W   = 2;
   localparam int PSTAT_W    = 2;
   localparam int SLOT_OUT_W = 4;
   localparam int COUNT_OUT_W = 6;
   localparam int QUORUM_W   = 7;

   localparam logic [QUORUM_W-1:0] QUORUM_RESET = 7'd66;
   localparam logic [QUORUM_W-1:0] PERCENT_FULL = 7'd100;

   typedef enum logic [CMD_W-1:0] {
      CMD_REGISTER = 2'd0,
      CMD_PROPOSE  = 2'd1,
      CMD_VOTE     = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_FULL        = 2'd1,
      ST_UNKNOWN     = 2'd2,
      ST_NOT_PENDING = 2'd3
   } status_type;

   typedef enum logic [PSTAT_W-1:0] {
      PS_PENDING  = 2'd0,
      PS_REJECTED = 2'd1,
      PS_APPLIED  = 2'd2
   } prop_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MUL_YES,
      S_MUL_QRM,
      S_DECIDE
   } state_type;

endpackage

`default_nettype wire

FILE: sv/qvt_table.sv
// ----------------------------------------------------------------------------
// qvt_table
// Proposal slot memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module qvt_table
   import qvt_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 20
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/quorum_vote_tally_table.sv
// ----------------------------------------------------------------------------
// quorum_vote_tally_table
// Table of proposals with voter registration, tallies and quorum decision.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Register, propose
// and unused commands complete in the accept cycle: busy stays low and the
// result is strobed on rsp_strobe in the next cycle. A vote passes through the
// busy states S_READ (slot memory read), S_MUL_YES (yes product), S_MUL_QRM
// (quorum product) and S_DECIDE (decide and write back), set by the registered
// memory read and the single multiplier used twice; a vote on an unknown slot
// ends in S_READ, one on a decided proposal in S_MUL_YES. Each result is on
// the rsp_ ports for exactly one cycle and must be taken then: the receiver
// cannot stall. Write csr_wr_data to the quorum percent only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module quorum_vote_tally_table
   import qvt_pkg::*;
#(
   parameter int VOTER_LIMIT    = 32,
   parameter int PROPOSAL_SLOTS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [CMD_W-1:0]       req_cmd,
   input  wire logic [INDEX_W-1:0]     req_proposal_index,
   input  wire logic                   req_approve,
   output logic                        rsp_strobe,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [SLOT_OUT_W-1:0]       rsp_slot,
   output logic [PSTAT_W-1:0]          rsp_proposal_status,
   output logic [COUNT_OUT_W-1:0]      rsp_yes_votes,
   output logic [COUNT_OUT_W-1:0]      rsp_no_votes,
   output logic [COUNT_OUT_W-1:0]      rsp_voter_total,
   input  wire logic                   csr_wr_en,
   input  wire logic [QUORUM_W-1:0]    csr_wr_data
);

   localparam int VOTE_W  = $clog2(VOTER_LIMIT + 1);
   localparam int CNT_W   = $clog2(PROPOSAL_SLOTS + 1);
   localparam int ADDR_W  = (PROPOSAL_SLOTS > 1) ? $clog2(PROPOSAL_SLOTS) : 1;
   localparam int CMP_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int ENTRY_W = 3 * VOTE_W + PSTAT_W;
   localparam int PROD_W  = VOTE_W + QUORUM_W;

   state_type state_ff, state_in;

   logic [QUORUM_W-1:0] quorum_ff;
   logic [VOTE_W-1:0]   voters_ff, voters_in;
   logic [CNT_W-1:0]    open_ff, open_in;
   cmd_type             cmd_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic                approve_ff;
   logic [PROD_W-1:0]   prod_yes_ff, prod_qrm_ff;

   logic                       rsp_strobe_ff;
   status_type                 rsp_status_ff;
   logic [SLOT_OUT_W-1:0]      rsp_slot_ff;
   prop_status_type            rsp_pstat_ff;
   logic [COUNT_OUT_W-1:0]     rsp_yes_ff, rsp_no_ff, rsp_voters_ff;

   logic                   accept;
   logic                   finish;
   status_type             res_status;
   logic [SLOT_OUT_W-1:0]  res_slot;
   prop_status_type        res_pstat;
   logic [VOTE_W-1:0]      res_yes, res_no;

   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;

   logic [VOTE_W-1:0]   mul_a;
   logic [QUORUM_W-1:0] mul_b;
   logic [PROD_W-1:0]   mul_out;

   logic [CMP_W-1:0]   idx_cmp, open_cmp;
   logic               unknown;
   prop_status_type    rd_pstat, new_pstat;
   logic [VOTE_W-1:0]  rd_yes, rd_no, rd_elect, yes_new, no_new;
   logic [VOTE_W:0]    cast_sum;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign idx_cmp  = CMP_W'(idx_ff);
   assign open_cmp = CMP_W'(open_ff);
   assign unknown  = (idx_cmp >= open_cmp);

   assign rd_yes   = rd_data[VOTE_W-1:0];
   assign rd_no    = rd_data[2*VOTE_W-1:VOTE_W];
   assign rd_elect = rd_data[3*VOTE_W-1:2*VOTE_W];
   assign rd_pstat = prop_status_type'(rd_data[ENTRY_W-1:3*VOTE_W]);

   assign yes_new  = rd_yes + VOTE_W'(approve_ff);
   assign no_new   = rd_no + VOTE_W'(!approve_ff);
   assign cast_sum = (VOTE_W+1)'(yes_new) + (VOTE_W+1)'(no_new);

   assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      if (rd_elect == '0) begin
         new_pstat = PS_REJECTED;
      end else if (prod_yes_ff >= prod_qrm_ff) begin
         new_pstat = PS_APPLIED;
      end else if (cast_sum == (VOTE_W+1)'(rd_elect)) begin
         new_pstat = PS_REJECTED;
      end else begin
         new_pstat = PS_PENDING;
      end
   end

   qvt_table #(
      .DEPTH  (PROPOSAL_SLOTS),
      .ADDR_W (ADDR_W),
      .DATA_W (ENTRY_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && cmd_type'(req_cmd) == CMD_VOTE) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = unknown ? S_IDLE : S_MUL_YES;
         end
         S_MUL_YES: begin
            state_in = (rd_pstat != PS_PENDING) ? S_IDLE : S_MUL_QRM;
         end
         S_MUL_QRM: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      finish     = 1'b0;
      res_status = ST_OK;
      res_slot   = '0;
      res_pstat  = PS_PENDING;
      res_yes    = '0;
      res_no     = '0;
      voters_in  = voters_ff;
      open_in    = open_ff;
      wr_en      = 1'b0;
      wr_addr    = ADDR_W'(open_ff);
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = ADDR_W'(idx_cmp);
      mul_a      = rd_yes;
      mul_b      = PERCENT_FULL;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_cmd))
                  CMD_REGISTER: begin
                     finish = 1'b1;
                     if (voters_ff >= VOTE_W'(VOTER_LIMIT)) begin
                        res_status = ST_FULL;
                     end else begin
                        voters_in = voters_ff + VOTE_W'(1);
                     end
                  end
                  CMD_PROPOSE: begin
                     finish = 1'b1;
                     if (open_ff >= CNT_W'(PROPOSAL_SLOTS)) begin
                        res_status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_data  = {PS_PENDING, voters_ff, {VOTE_W{1'b0}}, {VOTE_W{1'b0}}};
                        open_in  = open_ff + CNT_W'(1);
                        res_slot = SLOT_OUT_W'(open_ff);
                     end
                  end
                  CMD_VOTE: begin
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            if (unknown) begin
               finish     = 1'b1;
               res_status = ST_UNKNOWN;
            end else begin
               rd_en = 1'b1;
            end
         end
         S_MUL_YES: begin
            if (rd_pstat != PS_PENDING) begin
               finish     = 1'b1;
               res_status = ST_NOT_PENDING;
               res_slot   = SLOT_OUT_W'(idx_ff);
               res_pstat  = rd_pstat;
               res_yes    = rd_yes;
               res_no     = rd_no;
            end
            mul_a = yes_new;
            mul_b = PERCENT_FULL;
         end
         S_MUL_QRM: begin
            mul_a = rd_elect;
            mul_b = quorum_ff;
         end
         S_DECIDE: begin
            finish    = 1'b1;
            wr_en     = 1'b1;
            wr_addr   = ADDR_W'(idx_cmp);
            wr_data   = {new_pstat, rd_elect, no_new, yes_new};
            res_slot  = SLOT_OUT_W'(idx_ff);
            res_pstat = new_pstat;
            res_yes   = yes_new;
            res_no    = no_new;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         quorum_ff     <= QUORUM_RESET;
         voters_ff     <= '0;
         open_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         voters_ff     <= voters_in;
         open_ff       <= open_in;
         rsp_strobe_ff <= finish;
         if (csr_wr_en) begin
            quorum_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= cmd_type'(req_cmd);
         idx_ff     <= req_proposal_index;
         approve_ff <= req_approve;
      end
      if (state_ff == S_MUL_YES) begin
         prod_yes_ff <= mul_out;
      end
      if (state_ff == S_MUL_QRM) begin
         prod_qrm_ff <= mul_out;
      end
      if (finish) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_slot;
         rsp_pstat_ff  <= res_pstat;
         rsp_yes_ff    <= COUNT_OUT_W'(res_yes);
         rsp_no_ff     <= COUNT_OUT_W'(res_no);
         rsp_voters_ff <= COUNT_OUT_W'(voters_in);
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_proposal_status = rsp_pstat_ff;
   assign rsp_yes_votes       = rsp_yes_ff;
   assign rsp_no_votes        = rsp_no_ff;
   assign rsp_voter_total     = rsp_voters_ff;

   a_voter_limit: assert property (@(posedge clock) disable iff (reset)
      voters_ff <= VOTE_W'(VOTER_LIMIT))
      else $error("voter count above limit");

   a_slot_limit: assert property (@(posedge clock) disable iff (reset)
      open_ff <= CNT_W'(PROPOSAL_SLOTS))
      else $error("open proposal count above slot count");

   a_vote_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd_type'(req_cmd) == CMD_VOTE) |=> busy)
      else $error("vote transaction did not hold busy");

   a_decide_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |=> (rsp_strobe && rsp_status == ST_OK))
      else $error("decided vote gave no ok result");

   a_cmd_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL_YES) |-> (cmd_ff == CMD_VOTE))
      else $error("vote sequence running for another command");

endmodule

`default_nettype wire
